>>> rtl/ttbc_pkg.sv
package ttbc_pkg;

  // request kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_MOVE   = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         layer;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [9:0]         size_w;
    logic [9:0]         size_h;
    logic [7:0]         attr;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } ttbc_in_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] hit_attr;
    logic       status;
  } ttbc_out_t;

  // one stored tile, all fields in one memory word
  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [9:0]  width;
    logic [9:0]  height;
    logic [7:0]  attr;
  } ttbc_tile_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } ttbc_state_t;

endpackage

>>> rtl/tile_table_box_collision.sv
// Clear and append: the result passes from ST_FINISH into the output register. Query and
// move: scan the layer's stored tiles through one registered read port, one tile per cycle,
// then pass the result through ST_FINISH; a query stops at its first hit. The next request
// can be taken in the same cycle that the result becomes valid. One request in work at a
// time; in_ready is high only while idle, and an unaccepted result delays the next one.
// Synchronous active-low reset goes idle, drops any result and empties every layer count.
module tile_table_box_collision
  import ttbc_pkg::*;
#(
  parameter int LAYERS = 4,
  parameter int TILES  = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ttbc_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ttbc_out_t out_data
);

  localparam int DEPTH = LAYERS * TILES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int IW    = (TILES > 1) ? $clog2(TILES) : 1;
  localparam int CW    = $clog2(TILES + 1);

  // tile memory: one write port, one registered read port
  ttbc_tile_t mem [DEPTH];
  ttbc_tile_t rdata_r;
  logic       mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  ttbc_tile_t mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // control and request registers
  ttbc_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r [LAYERS];
  logic [CW-1:0] cnt_nxt [LAYERS];
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          dv_r, dv_nxt;
  logic [AW-1:0] daddr_r, daddr_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [7:0]    attr_r, attr_nxt;
  logic [15:0]   dx_r, dx_nxt;
  logic [15:0]   dy_r, dy_nxt;
  logic signed [17:0] px_r, px_nxt;
  logic signed [17:0] py_r, py_nxt;
  logic signed [17:0] qx_end_r, qx_end_nxt;
  logic signed [17:0] qy_end_r, qy_end_nxt;
  ttbc_out_t     res_r, res_nxt;
  ttbc_out_t     out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  // per-tile compare unit
  logic signed [17:0] tl_s, tt_s, tr_s, tb_s;
  logic               overlap;

  always_comb begin
    tl_s = 18'(signed'(rdata_r.left));
    tt_s = 18'(signed'(rdata_r.top));
    tr_s = tl_s + 18'(rdata_r.width);
    tb_s = tt_s + 18'(rdata_r.height);
    overlap = (tl_s < qx_end_r) && (px_r < tr_s) && (tt_s < qy_end_r) && (py_r < tb_s);
  end

  // sequencer
  logic          lay_ok;
  logic [LW-1:0] lyr;
  logic [CW-1:0] n_cur;
  logic          issue;
  logic          stop;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    rd_cnt_nxt    = rd_cnt_r;
    dv_nxt        = 1'b0;
    daddr_nxt     = daddr_r;
    base_nxt      = base_r;
    op_nxt        = op_r;
    attr_nxt      = attr_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    qx_end_nxt    = qx_end_r;
    qy_end_nxt    = qy_end_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = daddr_r;
    mem_wdata     = rdata_r;
    mem_raddr     = base_r + AW'(rd_cnt_r[IW-1:0]);
    in_ready      = (state_r == ST_IDLE);
    lay_ok        = (int'(in_data.layer) < LAYERS);
    lyr           = LW'(in_data.layer);
    n_cur         = lay_ok ? cnt_r[lyr] : '0;
    issue         = (rd_cnt_r < n_r);
    stop          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt    = '0;
          op_nxt     = in_data.kind;
          attr_nxt   = in_data.attr;
          dx_nxt     = in_data.dx;
          dy_nxt     = in_data.dy;
          px_nxt     = 18'(in_data.pos_x);
          py_nxt     = 18'(in_data.pos_y);
          qx_end_nxt = 18'(in_data.pos_x) + 18'(in_data.size_w);
          qy_end_nxt = 18'(in_data.pos_y) + 18'(in_data.size_h);
          base_nxt   = AW'(lyr) * AW'(TILES);
          n_nxt      = n_cur;
          rd_cnt_nxt = '0;
          state_nxt  = ST_FINISH;
          unique case (in_data.kind)
            KIND_CLEAR: begin
              if (lay_ok) begin
                cnt_nxt[lyr] = '0;
              end
            end
            KIND_APPEND: begin
              if (!lay_ok || (n_cur == CW'(TILES))) begin
                res_nxt.status = 1'b1;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = AW'(lyr) * AW'(TILES) + AW'(n_cur[IW-1:0]);
                mem_wdata.left   = in_data.pos_x;
                mem_wdata.top    = in_data.pos_y;
                mem_wdata.width  = in_data.size_w;
                mem_wdata.height = in_data.size_h;
                mem_wdata.attr   = in_data.attr;
                cnt_nxt[lyr]     = n_cur + CW'(1);
              end
            end
            KIND_QUERY, KIND_MOVE: begin
              if (lay_ok) begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // data stage: entry read in the previous cycle
        if (dv_r) begin
          if (op_r == KIND_QUERY) begin
            if (overlap) begin
              res_nxt.hit      = 1'b1;
              res_nxt.hit_attr = rdata_r.attr;
              stop             = 1'b1;
            end
          end else if (rdata_r.attr == attr_r) begin
            mem_we         = 1'b1;
            mem_waddr      = daddr_r;
            mem_wdata.left = rdata_r.left + dx_r;
            mem_wdata.top  = rdata_r.top + dy_r;
          end
        end
        // address stage
        if (stop) begin
          state_nxt = ST_FINISH;
        end else if (issue) begin
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          dv_nxt     = 1'b1;
          daddr_nxt  = mem_raddr;
        end else if (!dv_r) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LAYERS; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    rd_cnt_r <= rd_cnt_nxt;
    daddr_r  <= daddr_nxt;
    base_r   <= base_nxt;
    op_r     <= op_nxt;
    attr_r   <= attr_nxt;
    dx_r     <= dx_nxt;
    dy_r     <= dy_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    qx_end_r <= qx_end_nxt;
    qy_end_r <= qy_end_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
